### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define TDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds across reset
`define TDP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tdp_pkg.sv
// types, constants and codes of the touch report packet decoder
package tdp_pkg;

  localparam int PACKET_BYTES    = 21;
  localparam int FINGER_SLOTS    = 5;
  localparam int QUEUE_DEPTH     = 2;
  localparam int POS_W           = $clog2(PACKET_BYTES);
  localparam int SLOT_W          = $clog2(FINGER_SLOTS);
  localparam int FIRST_SLOT_BYTE = 2;
  localparam int WIDTH_BYTE      = 18;
  localparam int OUT_TDATA_W     = 40;

  localparam logic [7:0]  TYPE_REPORT  = 8'h5D;
  localparam logic [7:0]  TYPE_NOISE   = 8'h40;
  localparam logic [7:0]  NOISY_CODE   = 8'h41;
  localparam logic [7:0]  TYPE_HELLO   = 8'h55;
  localparam logic [7:0]  TYPE_CALIB   = 8'h66;
  localparam logic [15:0] NEW_WIDTH_FW = 16'h0026;
  localparam logic [3:0]  OLD_WIDTH    = 4'd2;

  typedef enum logic [2:0] {
    KIND_CONTACT    = 3'd0,
    KIND_START      = 3'd1,
    KIND_END        = 3'd2,
    KIND_REPORT_END = 3'd3,
    KIND_NOISE      = 3'd4,
    KIND_HELLO      = 3'd5,
    KIND_CALIB      = 3'd6,
    KIND_UNKNOWN    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_END
  } back_state_t;

  // one classified packet; kind is the final result's kind
  typedef struct packed {
    kind_t                              kind;
    logic                               noisy;
    logic [2:0]                         count;
    logic [FINGER_SLOTS-1:0]            now;
    logic [FINGER_SLOTS-1:0][11:0]      x;
    logic [FINGER_SLOTS-1:0][11:0]      y;
    logic [FINGER_SLOTS-1:0][3:0]       w;
  } pkt_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  finger;
    logic [11:0] x;
    logic [11:0] y;
    logic [3:0]  w;
    logic [2:0]  total;
    logic        noisy;
    logic        last;
  } res_t;

endpackage

### rtl/tdp_queue.sv
// small fifo of decoded packets between the front and back parts
module tdp_queue #(
  parameter int DEPTH = tdp_pkg::QUEUE_DEPTH,
  parameter int WIDTH = $bits(tdp_pkg::pkt_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

### rtl/tdp_front.sv
// front part: collects packet bytes and classifies the finished packet
module tdp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   fw_version,
  input  logic [7:0]    byte_in,
  input  logic          start_in,
  input  logic          in_fire,
  output tdp_pkg::pkt_t pkt,
  output logic          pkt_push
);
  import tdp_pkg::*;

  logic [POS_W-1:0] pos_r, wr_pos;
  logic             last_byte;
  logic [7:0]       store_r [PACKET_BYTES-1];
  logic [7:0]       pb [PACKET_BYTES];

  assign wr_pos    = start_in ? '0 : pos_r;
  assign last_byte = (wr_pos == POS_W'(PACKET_BYTES - 1));
  assign pkt_push  = in_fire && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire) begin
      pos_r <= last_byte ? '0 : wr_pos + 1'b1;
    end
  end

  // the final byte is decoded straight from the port
  always_ff @(posedge clk) begin
    if (in_fire && !last_byte) begin
      store_r[wr_pos] <= byte_in;
    end
  end

  for (genvar k = 0; k < PACKET_BYTES - 1; k++) begin : g_pb
    assign pb[k] = store_r[k];
  end
  assign pb[PACKET_BYTES-1] = byte_in;

  always_comb begin
    logic [7:0] wb;
    pkt       = '0;
    pkt.noisy = (pb[1] == NOISY_CODE);
    pkt.count = pb[1][2:0];
    pkt.now   = pb[1][7:3];
    case (pb[0])
      TYPE_REPORT: pkt.kind = KIND_REPORT_END;
      TYPE_NOISE:  pkt.kind = KIND_NOISE;
      TYPE_HELLO:  pkt.kind = KIND_HELLO;
      TYPE_CALIB:  pkt.kind = KIND_CALIB;
      default:     pkt.kind = KIND_UNKNOWN;
    endcase
    for (int i = 0; i < FINGER_SLOTS; i++) begin
      pkt.x[i] = {pb[FIRST_SLOT_BYTE + 3*i][7:4], pb[FIRST_SLOT_BYTE + 3*i + 1]};
      pkt.y[i] = {pb[FIRST_SLOT_BYTE + 3*i][3:0], pb[FIRST_SLOT_BYTE + 3*i + 2]};
      wb = pb[WIDTH_BYTE + i/2];
      if (fw_version < NEW_WIDTH_FW) pkt.w[i] = OLD_WIDTH;
      else                           pkt.w[i] = ((i & 1) != 0) ? wb[3:0] : wb[7:4];
    end
  end
endmodule

### rtl/tdp_back.sv
// back part: walks finger slots, tracks contacts and drives the result register
module tdp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  tdp_pkg::pkt_t q_data,
  output logic          q_pop,
  output tdp_pkg::res_t res,
  output logic          res_valid,
  input  logic          res_ready
);
  import tdp_pkg::*;

  back_state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  pkt_t                    ent_r, ent_nxt;
  logic [FINGER_SLOTS-1:0] rel_r, rel_nxt, prs_r, prs_nxt, mask_r, mask_nxt;
  logic                    trk_r, trk_nxt, tracking_r, tracking_nxt;
  logic [23:0]             lastpos_r [FINGER_SLOTS];
  res_t                    out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic        can_load, emit, lp_we;
  logic        hit, store_hit, use_stored;
  logic [23:0] lp_wdata, sp;
  res_t        emit_res;
  logic [FINGER_SLOTS-1:0] diff;

  assign can_load  = !out_valid_r || res_ready;
  assign res       = out_r;
  assign res_valid = out_valid_r;
  assign sp        = lastpos_r[idx_r];
  assign diff      = q_data.now ^ mask_r;

  // decide what the current slot yields
  always_comb begin
    hit        = 1'b0;
    use_stored = 1'b0;
    store_hit  = 1'b0;
    if (ent_r.count == 3'd0) begin
      hit        = trk_r && rel_r[idx_r];
      use_stored = 1'b1;
    end else if ((ent_r.now[idx_r] | rel_r[idx_r]) == 1'b0) begin
      hit = 1'b0;
    end else if (trk_r && rel_r[idx_r]) begin
      hit        = 1'b1;
      use_stored = 1'b1;
    end else begin
      hit       = 1'b1;
      store_hit = trk_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ent_nxt       = ent_r;
    rel_nxt       = rel_r;
    prs_nxt       = prs_r;
    mask_nxt      = mask_r;
    trk_nxt       = trk_r;
    tracking_nxt  = tracking_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    lp_we         = 1'b0;
    lp_wdata      = {ent_r.x[idx_r], ent_r.y[idx_r]};
    emit_res      = '0;
    emit_res.kind = KIND_CONTACT;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
          trk_nxt = tracking_r;
          idx_nxt = '0;
          rel_nxt = '0;
          prs_nxt = '0;
          if (q_data.kind == KIND_REPORT_END) begin
            state_nxt = ST_SLOT;
            if (tracking_r && (q_data.now != mask_r)) begin
              rel_nxt  = diff & ~q_data.now;
              prs_nxt  = diff & q_data.now;
              mask_nxt = q_data.now;
            end
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_SLOT: begin
        emit_res.finger = 3'(idx_r);
        emit_res.total  = ent_r.count;
        if (use_stored) begin
          emit_res.kind = KIND_END;
          emit_res.x    = sp[23:12];
          emit_res.y    = sp[11:0];
        end else begin
          emit_res.kind = (trk_r && prs_r[idx_r]) ? KIND_START : KIND_CONTACT;
          emit_res.x    = ent_r.x[idx_r];
          emit_res.y    = ent_r.y[idx_r];
          emit_res.w    = ent_r.w[idx_r];
        end
        if (!hit || can_load) begin
          emit  = hit;
          lp_we = hit && store_hit;
          if (idx_r == SLOT_W'(FINGER_SLOTS - 1)) state_nxt = ST_END;
          else                                    idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_END: begin
        emit_res.kind  = ent_r.kind;
        emit_res.last  = 1'b1;
        emit_res.total = (ent_r.kind == KIND_REPORT_END) ? ent_r.count : 3'd0;
        emit_res.noisy = (ent_r.kind == KIND_NOISE) && ent_r.noisy;
        if (can_load) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          // a report with no fingers down ends tracking for good
          if (ent_r.kind == KIND_REPORT_END && ent_r.count == 3'd0) tracking_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_nxt       = emit ? emit_res : out_r;
    out_valid_nxt = emit ? 1'b1 : (res_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r  <= 1'b1;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FINGER_SLOTS; i++) lastpos_r[i] <= '0;
    end else begin
      tracking_r  <= tracking_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (lp_we) lastpos_r[idx_r] <= lp_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ent_r <= ent_nxt;
    rel_r <= rel_nxt;
    prs_r <= prs_nxt;
    trk_r <= trk_nxt;
    out_r <= out_nxt;
  end
endmodule

### rtl/touch_report_packet_decoder.sv
// top level of the touch report packet decoder
// Takes one packet byte per beat and accepts a byte every cycle while the packet
// queue (QUEUE_DEPTH decoded packets) has room; in_tready drops only when it is full.
// On the 21st byte the packet is classified and queued. The back part gives at most
// one result per cycle: a status packet is loaded, then gives its result; a touch
// report is loaded, walks every finger slot, then gives the report end; a held
// result register stalls the walk until it drains.
// out_tdata from bit 0: finger[2:0], x[14:3], y[26:15], width[30:27],
// finger total[33:31], noisy[34], zeros above; out_tuser is the result kind.
module touch_report_packet_decoder #(
  parameter int QUEUE_DEPTH = tdp_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // data_byte[7:0]
  input  logic                            in_tuser,   // packet_start
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tdp_pkg::OUT_TDATA_W-1:0] out_tdata,  // finger, x, y, width, total, noisy
  output logic [2:0]                      out_tuser,  // kind
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [15:0]                     cfg_wr_data
);
  import tdp_pkg::*;

  logic [15:0] fw_r;
  logic        in_fire, pkt_push, q_full, q_pop, q_valid;
  pkt_t        pkt, q_data;
  res_t        res;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n)         fw_r <= '0;
    else if (cfg_wr_en) fw_r <= cfg_wr_data;
  end

  tdp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fw_version (fw_r),
    .byte_in    (in_tdata),
    .start_in   (in_tuser),
    .in_fire    (in_fire),
    .pkt        (pkt),
    .pkt_push   (pkt_push)
  );

  tdp_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(pkt_t))
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pkt_push),
    .push_data (pkt),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  tdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (out_tvalid),
    .res_ready (out_tready)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {5'b0, res.noisy, res.total, res.w, res.y, res.x, res.finger};
endmodule

### rtl/tdp_checker.sv
// port-level checks of the decoder, bound to the top level
`include "assert_macros.svh"

module tdp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tdp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]                      out_tuser,
  input logic                            out_tlast
);
  import tdp_pkg::*;

  logic                   contact_kind;
  logic                   contact_beat;
  logic                   summary_beat;
  logic                   out_stall;
  logic [OUT_TDATA_W+3:0] out_beat;

  assign contact_kind = (out_tuser == KIND_CONTACT) || (out_tuser == KIND_START) ||
                        (out_tuser == KIND_END);
  assign contact_beat = out_tvalid && contact_kind;
  assign summary_beat = out_tvalid && !contact_kind;
  assign out_stall    = out_tvalid && !out_tready;
  assign out_beat     = {out_tlast, out_tuser, out_tdata};

  `TDP_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `TDP_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_beat), "held beat changed")
  `TDP_ASSERT(a_contact_not_last, contact_beat |-> !out_tlast, "contact beat marked last")
  `TDP_ASSERT(a_summary_last, summary_beat |-> out_tlast && !(|out_tdata[2:0]), "summary beat")
endmodule

bind touch_report_packet_decoder tdp_checker u_tdp_checker (.*);

### verif/tb_touch_report_packet_decoder.sv
// testbench for the touch report packet decoder: directed and random packets against a predictor
`timescale 1ns / 100ps

module tb_touch_report_packet_decoder;
  import tdp_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 250;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_wr_en;
  logic [15:0]            cfg_wr_data;

  touch_report_packet_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // decoder state as the testbench sees it
  logic [15:0] fw_version;
  int          byte_pos;
  logic [7:0]  pkt_bytes [PACKET_BYTES];
  logic        tracking;
  logic [4:0]  pressed;
  logic [23:0] last_xy [FINGER_SLOTS];

  res_t        touch_events [$];
  logic [7:0]  frame [PACKET_BYTES];
  int          failures;
  int          quiet_cycles;
  logic        gaps_on;
  logic        long_hold_req;

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  function automatic res_t touch_event(kind_t k, int slot, logic [11:0] x, logic [11:0] y,
                                       logic [3:0] w, logic [2:0] total, logic noisy);
    res_t r;
    r.kind   = k;
    r.finger = slot[2:0];
    r.x      = x;
    r.y      = y;
    r.w      = w;
    r.total  = total;
    r.noisy  = noisy;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic decode_touch_report();
    logic [2:0]  cnt;
    logic [4:0]  now_mask;
    logic [4:0]  rel;
    logic [4:0]  prs;
    logic [7:0]  b0;
    logic [7:0]  wb;
    logic [11:0] px;
    logic [11:0] py;
    logic [3:0]  wd;
    int          base;
    cnt      = pkt_bytes[1][2:0];
    now_mask = pkt_bytes[1][7:3];
    rel      = '0;
    prs      = '0;
    if (tracking && now_mask != pressed) begin
      rel     = pressed & ~now_mask;
      prs     = now_mask & ~pressed;
      pressed = now_mask;
    end
    for (int i = 0; i < FINGER_SLOTS; i++) begin
      if (tracking && rel[i]) begin
        // lifted finger reports where it was last seen
        touch_events.push_back(touch_event(KIND_END, i, last_xy[i][23:12], last_xy[i][11:0],
                                           4'd0, cnt, 1'b0));
      end else if (cnt != 3'd0 && now_mask[i]) begin
        base = FIRST_SLOT_BYTE + 3 * i;
        b0   = pkt_bytes[base];
        px   = {b0[7:4], pkt_bytes[base + 1]};
        py   = {b0[3:0], pkt_bytes[base + 2]};
        if (tracking) last_xy[i] = {px, py};
        if (fw_version < NEW_WIDTH_FW) begin
          wd = OLD_WIDTH;
        end else begin
          wb = pkt_bytes[WIDTH_BYTE + i / 2];
          wd = (i % 2 == 1) ? wb[3:0] : wb[7:4];
        end
        touch_events.push_back(touch_event((tracking && prs[i]) ? KIND_START : KIND_CONTACT,
                                           i, px, py, wd, cnt, 1'b0));
      end
    end
    if (cnt == 3'd0) tracking = 1'b0;
    touch_events.push_back(touch_event(KIND_REPORT_END, 0, '0, '0, '0, cnt, 1'b0));
  endtask

  // called once per accepted byte
  task automatic track_byte(input logic [7:0] b, input logic start);
    res_t tail;
    if (start) byte_pos = 0;
    if (byte_pos >= PACKET_BYTES) byte_pos = 0;
    pkt_bytes[byte_pos] = b;
    byte_pos++;
    if (byte_pos < PACKET_BYTES) return;
    byte_pos = 0;
    case (pkt_bytes[0])
      TYPE_REPORT: decode_touch_report();
      TYPE_NOISE:  touch_events.push_back(touch_event(KIND_NOISE, 0, '0, '0, '0, '0,
                                                      pkt_bytes[1] == NOISY_CODE));
      TYPE_HELLO:  touch_events.push_back(touch_event(KIND_HELLO, 0, '0, '0, '0, '0, 1'b0));
      TYPE_CALIB:  touch_events.push_back(touch_event(KIND_CALIB, 0, '0, '0, '0, '0, 1'b0));
      default:     touch_events.push_back(touch_event(KIND_UNKNOWN, 0, '0, '0, '0, '0, 1'b0));
    endcase
    tail = touch_events.pop_back();
    tail.last = 1'b1;
    touch_events.push_back(tail);
  endtask

  task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (touch_events.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual kind %0d data %0h",
                 $time, out_tuser, out_tdata);
        failures++;
      end else begin
        want = touch_events.pop_front();
        check_field("kind",   12'(want.kind),  12'(out_tuser));
        check_field("finger", 12'(want.finger), 12'(out_tdata[2:0]));
        check_field("x",      want.x,          out_tdata[14:3]);
        check_field("y",      want.y,          out_tdata[26:15]);
        check_field("width",  12'(want.w),     12'(out_tdata[30:27]));
        check_field("total",  12'(want.total), 12'(out_tdata[33:31]));
        check_field("noisy",  12'(want.noisy), 12'(out_tdata[34]));
        check_field("pad",    12'd0,           12'(out_tdata[OUT_TDATA_W-1:35]));
        check_field("tlast",  12'(want.last),  12'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("touch_report_packet_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(1, 7) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    track_byte(b, start);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic start);
    for (int i = 0; i < PACKET_BYTES; i++) send_byte(frame[i], (i == 0) ? start : 1'b0);
  endtask

  // fill < 0 gives random bytes
  task automatic fill_frame(input int fill);
    for (int i = 0; i < PACKET_BYTES; i++) frame[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
  endtask

  task automatic send_report(input logic [2:0] cnt, input logic [4:0] mask, input int fill,
                             input logic start);
    fill_frame(fill);
    frame[0] = TYPE_REPORT;
    frame[1] = {mask, cnt};
    send_frame(start);
  endtask

  task automatic send_status(input logic [7:0] code, input logic [7:0] second, input logic start);
    fill_frame(-1);
    frame[0] = code;
    frame[1] = second;
    send_frame(start);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (touch_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_firmware(input logic [15:0] version);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= version;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    fw_version = version;
  endtask

  task automatic test_status_packets();
    set_firmware(16'h0000);
    send_status(TYPE_NOISE, NOISY_CODE, 1'b1);
    send_status(TYPE_HELLO, 8'h00, 1'b1);
    send_status(TYPE_CALIB, 8'hFF, 1'b1);
    send_status(8'h00, 8'h5D, 1'b0);
  endtask

  task automatic test_touch_tracking();
    set_firmware(16'h0025);
    send_report(3'd1, 5'b00001, 8'h00, 1'b1);
    set_firmware(NEW_WIDTH_FW);
    send_report(3'd3, 5'b10110, -1, 1'b1);
    send_report(3'd5, 5'b11111, 8'hFF, 1'b0);
  endtask

  task automatic test_packet_framing();
    // a start mark mid-packet drops the partial packet
    for (int i = 0; i < 9; i++) send_byte(8'($urandom), (i == 0));
    send_status(TYPE_NOISE, 8'h40, 1'b1);
  endtask

  task automatic test_backpressure();
    set_firmware(16'hFFFF);
    gaps_on = 1'b0;
    @(posedge clk);
    long_hold_req = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 4; i++) send_report(3'($urandom_range(1, 7)), 5'($urandom), -1, 1'b1);
    wait_idle();
  endtask

  task automatic send_random_unit(input logic allow_zero);
    int         pick;
    logic [2:0] cnt;
    logic [7:0] code;
    pick = $urandom_range(0, 9);
    cnt  = (allow_zero && $urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    if (pick <= 5) begin
      send_report(cnt, 5'($urandom), -1, 1'($urandom));
    end else if (pick == 6) begin
      case ($urandom_range(0, 4))
        0:       code = TYPE_NOISE;
        1:       code = TYPE_HELLO;
        2:       code = TYPE_CALIB;
        default: code = 8'($urandom);
      endcase
      if (code == TYPE_REPORT) code = 8'h5C;
      send_status(code, $urandom_range(0, 1) ? NOISY_CODE : 8'($urandom), 1'($urandom));
    end else if (pick == 7) begin
      // truncated packet, then a marked one
      send_byte($urandom_range(0, 1) ? TYPE_REPORT : 8'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 19)) send_byte(8'($urandom), 1'b0);
      send_report(cnt, 5'($urandom), -1, 1'b1);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
      send_status(TYPE_NOISE, NOISY_CODE, 1'b1);
    end else begin
      send_report(cnt, 5'($urandom), $urandom_range(0, 1) ? 8'hFF : 8'h00, 1'($urandom));
    end
  endtask

  task automatic test_random_tracking();
    set_firmware(16'($urandom_range(NEW_WIDTH_FW, 16'hFFFF)));
    send_random_unit(1'b0);
    set_firmware(16'($urandom_range(0, 16'h0025)));
    send_random_unit(1'b0);
  endtask

  task automatic test_release_all();
    set_firmware(NEW_WIDTH_FW);
    send_report(3'd3, 5'b10101, -1, 1'b1);
    // count zero lifts every finger and stops tracking for good
    send_report(3'd0, 5'b00000, -1, 1'b1);
    send_report(3'd6, 5'b11111, -1, 1'b1);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    gaps_on       = 1'b1;
    long_hold_req = 1'b0;
    failures      = 0;
    quiet_cycles  = 0;
    fw_version    = '0;
    byte_pos      = 0;
    tracking      = 1'b1;
    pressed       = '0;
    for (int i = 0; i < PACKET_BYTES; i++) pkt_bytes[i] = '0;
    for (int i = 0; i < FINGER_SLOTS; i++) last_xy[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_status_packets();
    test_touch_tracking();
    test_packet_framing();
    test_random_tracking();
    test_release_all();
    // final stretch: no input gaps, one long result hold-off
    test_backpressure();
    wait_idle();

    if (failures == 0) begin
      $display("touch_report_packet_decoder regression: pass");
    end else begin
      $display("touch_report_packet_decoder regression: fail");
    end
    $finish;
  end

endmodule
